@@ hdl/flvp_pkg.sv @@
// Shared types and constants for the FLV tag stream parser.
package flvp_pkg;

  localparam int unsigned POSITION_BITS_DEF = 48;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_BAD   = 2'd1;
  localparam logic [1:0] STATUS_UNSUP = 2'd2;

  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_SKIP   = 3'd1;
  localparam logic [2:0] KIND_PREFIX = 3'd2;
  localparam logic [2:0] KIND_AUDIO  = 3'd3;
  localparam logic [2:0] KIND_VIDEO  = 3'd4;
  localparam logic [2:0] KIND_SCRIPT = 3'd5;

  localparam logic [7:0] SIG_F          = 8'h46;
  localparam logic [7:0] SIG_L          = 8'h4C;
  localparam logic [7:0] SIG_V          = 8'h56;
  localparam logic [7:0] VERSION_ONE    = 8'h01;
  localparam logic [7:0] FLAG_RSVD_MASK = 8'hFA;

  localparam logic [7:0] TAG_AUDIO  = 8'd8;
  localparam logic [7:0] TAG_VIDEO  = 8'd9;
  localparam logic [7:0] TAG_SCRIPT = 8'd18;

  localparam logic [3:0] AUDIO_FMT_AAC   = 4'd10;
  localparam logic [3:0] VIDEO_CODEC_VP6  = 4'd4;
  localparam logic [3:0] VIDEO_CODEC_VP6A = 4'd5;
  localparam logic [3:0] VIDEO_CODEC_AVC  = 4'd7;

  localparam logic [32:0] HEADER_LEN     = 33'd9;
  localparam logic [32:0] PREFIX_LEN     = 33'd11;
  localparam logic [32:0] SUFFIX_LEN     = 33'd4;
  localparam logic [31:0] MIN_DATA_OFFSET = 32'd9;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  block_kind;
    logic [7:0]  tag_code;
    logic [23:0] body_len;
    logic [31:0] timestamp;
    logic [3:0]  format_high;
    logic [3:0]  format_low;
    logic        has_audio;
    logic        has_video;
    logic [2:0]  packet_offset;
    logic [23:0] packet_size;
    logic [47:0] stream_pos;
  } result_t;

endpackage

@@ hdl/flv_tag_stream_parser.sv @@
// Top level: input register, parser and output register with skid stage.
// A block's last byte is registered at the input, then its descriptor at the output.
// Throughput: one transfer per cycle when not stalled, set by the single-pass parser.
// Input stalls only while two descriptors wait (output and skid registers both full).
// Reset: parser expects the file header at position zero; input and output stages empty.
module flv_tag_stream_parser #(
  parameter int unsigned POSITION_BITS = flvp_pkg::POSITION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic [47:0] seek_position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [2:0]  block_kind_o,
  output logic [7:0]  tag_code_o,
  output logic [23:0] body_len_o,
  output logic [31:0] timestamp_o,
  output logic [3:0]  format_high_o,
  output logic [3:0]  format_low_o,
  output logic        has_audio_o,
  output logic        has_video_o,
  output logic [2:0]  packet_offset_o,
  output logic [23:0] packet_size_o,
  output logic [47:0] stream_pos_o
);

  logic              in_valid_q;
  logic              in_mode_q;
  logic [7:0]        in_byte_q;
  logic [47:0]       in_seek_q;
  logic              in_accept;
  logic              proc_en;
  logic              res_valid;
  flvp_pkg::result_t res;
  logic              out_valid_q;
  flvp_pkg::result_t out_q;
  logic              skid_valid_q;
  flvp_pkg::result_t skid_q;
  logic              out_take;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign proc_en    = in_valid_q && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  flvp_parser #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (proc_en),
    .mode_i          (in_mode_q),
    .data_byte_i     (in_byte_q),
    .seek_position_i (in_seek_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (proc_en) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_mode_q <= mode_i;
      in_byte_q <= data_byte_i;
      in_seek_q <= seek_position_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) skid_valid_q <= 1'b0;
    end else if (proc_en && res_valid) begin
      if (!out_valid_q || out_take) out_valid_q <= 1'b1;
      else skid_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) out_q <= skid_q;
    end else if (proc_en && res_valid) begin
      if (!out_valid_q || out_take) out_q <= res;
      else skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign block_kind_o    = out_q.block_kind;
  assign tag_code_o      = out_q.tag_code;
  assign body_len_o      = out_q.body_len;
  assign timestamp_o     = out_q.timestamp;
  assign format_high_o   = out_q.format_high;
  assign format_low_o    = out_q.format_low;
  assign has_audio_o     = out_q.has_audio;
  assign has_video_o     = out_q.has_video;
  assign packet_offset_o = out_q.packet_offset;
  assign packet_size_o   = out_q.packet_size;
  assign stream_pos_o    = out_q.stream_pos;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a descriptor while output register is empty");

  a_stalled_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_stall_o && in_valid_q) |=> in_valid_q)
    else $error("pending input item dropped while input was stalled");

  a_seek_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_en && in_mode_q) |-> !res_valid)
    else $error("seek produced a descriptor");

endmodule

@@ hdl/flvp_parser.sv @@
// Block walker: per-byte field capture, block counting and descriptor build.
module flvp_parser #(
  parameter int unsigned POSITION_BITS = flvp_pkg::POSITION_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              mode_i,
  input  logic [7:0]        data_byte_i,
  input  logic [47:0]       seek_position_i,
  output logic              res_valid_o,
  output flvp_pkg::result_t res_o
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SKIP   = 3'd1,
    PH_PREFIX = 3'd2,
    PH_AUDIO  = 3'd3,
    PH_VIDEO  = 3'd4,
    PH_SCRIPT = 3'd5
  } phase_e;

  phase_e                   phase_q, phase_d;
  logic [32:0]              idx_q, idx_d;
  logic [32:0]              blen_q, blen_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [7:0]               kind_q, kind_d;
  logic [23:0]              len_q, len_d;
  logic [31:0]              word_q, word_d;
  logic [7:0]               fmt_q, fmt_d;
  logic                     idnz_q, idnz_d;
  logic                     halted_q, halted_d;

  logic                     last;
  logic [3:0]               fhi;
  logic [3:0]               flo;
  logic [2:0]               off;
  logic [23:0]              psize;
  logic [1:0]               hdr_status;

  assign fhi   = fmt_d[7:4];
  assign flo   = fmt_d[3:0];
  assign last  = !(({1'b0, idx_q} + 34'd1) < {1'b0, blen_q});
  assign psize = (len_d > {21'd0, off}) ? (len_d - {21'd0, off}) : 24'd0;

  always_comb begin
    off = 3'd1;
    if (phase_q == PH_AUDIO) begin
      if (fhi == flvp_pkg::AUDIO_FMT_AAC) off = 3'd2;
    end else begin
      if (flo == flvp_pkg::VIDEO_CODEC_VP6 || flo == flvp_pkg::VIDEO_CODEC_VP6A) off = 3'd2;
      else if (flo == flvp_pkg::VIDEO_CODEC_AVC) off = 3'd7;
    end
  end

  always_comb begin
    if (idnz_d) hdr_status = flvp_pkg::STATUS_BAD;
    else if (fmt_d != flvp_pkg::VERSION_ONE) hdr_status = flvp_pkg::STATUS_UNSUP;
    else if ((kind_d & flvp_pkg::FLAG_RSVD_MASK) != 8'd0) hdr_status = flvp_pkg::STATUS_BAD;
    else if (word_d < flvp_pkg::MIN_DATA_OFFSET) hdr_status = flvp_pkg::STATUS_BAD;
    else hdr_status = flvp_pkg::STATUS_OK;
  end

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    blen_d      = blen_q;
    pos_d       = pos_q;
    kind_d      = kind_q;
    len_d       = len_q;
    word_d      = word_q;
    fmt_d       = fmt_q;
    idnz_d      = idnz_q;
    halted_d    = halted_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (en_i) begin
      if (mode_i) begin
        pos_d    = POSITION_BITS'(seek_position_i);
        phase_d  = PH_PREFIX;
        idx_d    = 33'd0;
        blen_d   = flvp_pkg::PREFIX_LEN;
        halted_d = 1'b0;
      end else if (!halted_q) begin
        case (phase_q)
          PH_HEADER: begin
            if (idx_q == 33'd0) idnz_d = (data_byte_i != flvp_pkg::SIG_F);
            else if (idx_q == 33'd1) begin
              if (data_byte_i != flvp_pkg::SIG_L) idnz_d = 1'b1;
            end else if (idx_q == 33'd2) begin
              if (data_byte_i != flvp_pkg::SIG_V) idnz_d = 1'b1;
            end else if (idx_q == 33'd3) fmt_d = data_byte_i;
            else if (idx_q == 33'd4) kind_d = data_byte_i;
            else word_d = {word_q[23:0], data_byte_i};
          end
          PH_PREFIX: begin
            if (idx_q == 33'd0) begin
              kind_d = data_byte_i;
              idnz_d = 1'b0;
            end else if (idx_q <= 33'd3) len_d = {len_q[15:0], data_byte_i};
            else if (idx_q == 33'd4) word_d = {24'd0, data_byte_i};
            else if (idx_q <= 33'd6) word_d = {8'd0, word_q[15:0], data_byte_i};
            else if (idx_q == 33'd7) word_d = {word_q[31:24] | data_byte_i, word_q[23:0]};
            else if (data_byte_i != 8'd0) idnz_d = 1'b1;
          end
          PH_SKIP: begin
          end
          default: begin
            if (idx_q == 33'd0) fmt_d = data_byte_i;
          end
        endcase

        if (!last) begin
          idx_d = idx_q + 33'd1;
        end else begin
          idx_d       = 33'd0;
          res_valid_o = 1'b1;
          case (phase_q)
            PH_HEADER: begin
              res_o.block_kind = flvp_pkg::KIND_HEADER;
              res_o.status     = hdr_status;
              res_o.has_audio  = kind_d[2];
              res_o.has_video  = kind_d[0];
              if (hdr_status != flvp_pkg::STATUS_OK) begin
                halted_d = 1'b1;
              end else begin
                pos_d   = pos_q + POSITION_BITS'(flvp_pkg::HEADER_LEN);
                blen_d  = {1'b0, word_d} - flvp_pkg::HEADER_LEN + flvp_pkg::SUFFIX_LEN;
                phase_d = PH_SKIP;
              end
            end
            PH_SKIP: begin
              res_o.block_kind = flvp_pkg::KIND_SKIP;
              pos_d   = pos_q + POSITION_BITS'(blen_q);
              blen_d  = flvp_pkg::PREFIX_LEN;
              phase_d = PH_PREFIX;
            end
            PH_PREFIX: begin
              res_o.block_kind = flvp_pkg::KIND_PREFIX;
              res_o.tag_code   = kind_d;
              res_o.body_len   = len_d;
              res_o.timestamp  = word_d;
              if (idnz_d) begin
                halted_d     = 1'b1;
                res_o.status = flvp_pkg::STATUS_UNSUP;
              end else begin
                pos_d  = pos_q + POSITION_BITS'(flvp_pkg::PREFIX_LEN);
                blen_d = {9'd0, len_d} + flvp_pkg::SUFFIX_LEN;
                if (kind_d == flvp_pkg::TAG_AUDIO) phase_d = PH_AUDIO;
                else if (kind_d == flvp_pkg::TAG_VIDEO) phase_d = PH_VIDEO;
                else if (kind_d == flvp_pkg::TAG_SCRIPT) phase_d = PH_SCRIPT;
                else begin
                  halted_d     = 1'b1;
                  res_o.status = flvp_pkg::STATUS_UNSUP;
                end
              end
            end
            default: begin
              pos_d           = pos_q + POSITION_BITS'(blen_q);
              blen_d          = flvp_pkg::PREFIX_LEN;
              phase_d         = PH_PREFIX;
              res_o.tag_code  = kind_d;
              res_o.body_len  = len_d;
              res_o.timestamp = word_d;
              if (phase_q == PH_SCRIPT) begin
                res_o.block_kind  = flvp_pkg::KIND_SCRIPT;
                res_o.packet_size = len_d;
              end else begin
                res_o.block_kind    = (phase_q == PH_AUDIO) ? flvp_pkg::KIND_AUDIO
                                                            : flvp_pkg::KIND_VIDEO;
                res_o.format_high   = fhi;
                res_o.format_low    = flo;
                res_o.packet_offset = off;
                res_o.packet_size   = psize;
              end
            end
          endcase
          res_o.stream_pos = 48'(pos_d);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      idx_q    <= '0;
      blen_q   <= flvp_pkg::HEADER_LEN;
      pos_q    <= '0;
      kind_q   <= '0;
      len_q    <= '0;
      word_q   <= '0;
      fmt_q    <= '0;
      idnz_q   <= 1'b0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      blen_q   <= blen_d;
      pos_q    <= pos_d;
      kind_q   <= kind_d;
      len_q    <= len_d;
      word_q   <= word_d;
      fmt_q    <= fmt_d;
      idnz_q   <= idnz_d;
      halted_q <= halted_d;
    end
  end

endmodule

@@ bench/flv_tag_stream_parser_tb.sv @@
// Testbench for the FLV tag stream parser: byte and seek stimulus, descriptor prediction and checks.
module flv_tag_stream_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import flvp_pkg::*;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_SEEK = 1'b1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = MODE_BYTE;
  logic [7:0]  data_byte_i = '0;
  logic [47:0] seek_position_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [2:0]  block_kind_o;
  logic [7:0]  tag_code_o;
  logic [23:0] body_len_o;
  logic [31:0] timestamp_o;
  logic [3:0]  format_high_o;
  logic [3:0]  format_low_o;
  logic        has_audio_o;
  logic        has_video_o;
  logic [2:0]  packet_offset_o;
  logic [23:0] packet_size_o;
  logic [47:0] stream_pos_o;

  flv_tag_stream_parser dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .mode_i(mode_i),
    .data_byte_i(data_byte_i),
    .seek_position_i(seek_position_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o(status_o),
    .block_kind_o(block_kind_o),
    .tag_code_o(tag_code_o),
    .body_len_o(body_len_o),
    .timestamp_o(timestamp_o),
    .format_high_o(format_high_o),
    .format_low_o(format_low_o),
    .has_audio_o(has_audio_o),
    .has_video_o(has_video_o),
    .packet_offset_o(packet_offset_o),
    .packet_size_o(packet_size_o),
    .stream_pos_o(stream_pos_o)
  );

  always #4 clk_i = ~clk_i;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned transfers_in = 0;
  int unsigned parsed_items = 0;
  int unsigned seeks_sent = 0;
  int unsigned descriptors_checked = 0;
  int unsigned mismatches = 0;

  result_t descriptor_q[$];

  // parser state as predicted
  logic [2:0]  flv_phase = KIND_HEADER;
  logic [32:0] flv_index = '0;
  logic [32:0] flv_len = HEADER_LEN;
  logic [47:0] flv_pos = '0;
  logic [7:0]  flv_type = '0;
  logic [23:0] flv_size = '0;
  logic [31:0] flv_word = '0;
  logic [7:0]  flv_fmt = '0;
  logic        flv_mismatch = 1'b0;
  logic        flv_halted = 1'b0;

  task automatic flv_parse_step(input logic m, input logic [7:0] b, input logic [47:0] p);
    result_t     r;
    logic [32:0] idx;
    logic [2:0]  off;
    idx = flv_index;
    r = '0;
    if (m == MODE_SEEK) begin
      flv_pos = p;
      flv_phase = KIND_PREFIX;
      flv_index = '0;
      flv_len = PREFIX_LEN;
      flv_halted = 1'b0;
      seeks_sent++;
      parsed_items++;
    end else if (!flv_halted) begin
      parsed_items++;
      case (flv_phase)
        KIND_HEADER: begin
          if (idx == 0) flv_mismatch = (b != SIG_F);
          else if (idx == 1) flv_mismatch = flv_mismatch | (b != SIG_L);
          else if (idx == 2) flv_mismatch = flv_mismatch | (b != SIG_V);
          else if (idx == 3) flv_fmt = b;
          else if (idx == 4) flv_type = b;
          else flv_word = {flv_word[23:0], b};
        end
        KIND_PREFIX: begin
          if (idx == 0) begin
            flv_type = b;
            flv_mismatch = 1'b0;
          end else if (idx <= 3) flv_size = {flv_size[15:0], b};
          else if (idx == 4) flv_word = {24'd0, b};
          else if (idx <= 6) flv_word = {8'd0, flv_word[15:0], b};
          else if (idx == 7) flv_word = {b, flv_word[23:0]};
          else if (b != 8'd0) flv_mismatch = 1'b1;
        end
        KIND_SKIP: ;
        default: if (idx == 0) flv_fmt = b;
      endcase
      if (idx + 33'd1 < flv_len) begin
        flv_index = idx + 33'd1;
      end else begin
        flv_index = '0;
        r.block_kind = flv_phase;
        case (flv_phase)
          KIND_HEADER: begin
            r.has_audio = flv_type[2];
            r.has_video = flv_type[0];
            if (flv_mismatch) r.status = STATUS_BAD;
            else if (flv_fmt != VERSION_ONE) r.status = STATUS_UNSUP;
            else if ((flv_type & FLAG_RSVD_MASK) != 8'd0) r.status = STATUS_BAD;
            else if (flv_word < MIN_DATA_OFFSET) r.status = STATUS_BAD;
            else r.status = STATUS_OK;
            if (r.status != STATUS_OK) begin
              flv_halted = 1'b1;
            end else begin
              flv_pos = flv_pos + 48'(HEADER_LEN);
              flv_len = {1'b0, flv_word} - HEADER_LEN + SUFFIX_LEN;
              flv_phase = KIND_SKIP;
            end
          end
          KIND_SKIP: begin
            flv_pos = flv_pos + 48'(flv_len);
            flv_len = PREFIX_LEN;
            flv_phase = KIND_PREFIX;
          end
          KIND_PREFIX: begin
            r.tag_code = flv_type;
            r.body_len = flv_size;
            r.timestamp = flv_word;
            if (flv_mismatch) begin
              r.status = STATUS_UNSUP;
              flv_halted = 1'b1;
            end else begin
              flv_pos = flv_pos + 48'(PREFIX_LEN);
              flv_len = {9'd0, flv_size} + SUFFIX_LEN;
              if (flv_type == TAG_AUDIO) flv_phase = KIND_AUDIO;
              else if (flv_type == TAG_VIDEO) flv_phase = KIND_VIDEO;
              else if (flv_type == TAG_SCRIPT) flv_phase = KIND_SCRIPT;
              else begin
                r.status = STATUS_UNSUP;
                flv_halted = 1'b1;
              end
            end
          end
          default: begin
            r.tag_code = flv_type;
            r.body_len = flv_size;
            r.timestamp = flv_word;
            flv_pos = flv_pos + 48'(flv_len);
            if (flv_phase == KIND_SCRIPT) begin
              r.packet_size = flv_size;
            end else begin
              r.format_high = flv_fmt[7:4];
              r.format_low = flv_fmt[3:0];
              if (flv_phase == KIND_AUDIO) begin
                off = (flv_fmt[7:4] == AUDIO_FMT_AAC) ? 3'd2 : 3'd1;
              end else if (flv_fmt[3:0] == VIDEO_CODEC_VP6 ||
                           flv_fmt[3:0] == VIDEO_CODEC_VP6A) begin
                off = 3'd2;
              end else if (flv_fmt[3:0] == VIDEO_CODEC_AVC) begin
                off = 3'd7;
              end else begin
                off = 3'd1;
              end
              r.packet_offset = off;
              r.packet_size = (flv_size > {21'd0, off}) ? flv_size - {21'd0, off} : 24'd0;
            end
            flv_len = PREFIX_LEN;
            flv_phase = KIND_PREFIX;
          end
        endcase
        r.stream_pos = flv_pos;
        descriptor_q.push_back(r);
      end
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input logic m, input logic [7:0] b, input logic [47:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    data_byte_i <= b;
    seek_position_i <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    flv_parse_step(m, b, p);
    transfers_in++;
    @(negedge clk_i);
  endtask

  function automatic logic [47:0] rand_pos();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic send_byte(input logic [7:0] b);
    send_item(MODE_BYTE, b, rand_pos());
  endtask

  task automatic seek_to(input logic [47:0] p);
    send_item(MODE_SEEK, 8'($urandom), p);
  endtask

  task automatic resync_prefix();
    if (flv_halted || flv_phase != KIND_PREFIX || flv_index != 0) seek_to(rand_pos());
  endtask

  // long bodies are cut short; the next tag seeks past them
  task automatic send_tag(input logic [7:0] kind, input logic [23:0] size,
                          input logic [31:0] ts, input logic [23:0] sid,
                          input logic [7:0] first);
    logic [7:0] pre [11];
    pre = '{kind, size[23:16], size[15:8], size[7:0], ts[23:16], ts[15:8], ts[7:0],
            ts[31:24], sid[23:16], sid[15:8], sid[7:0]};
    resync_prefix();
    foreach (pre[k]) send_byte(pre[k]);
    if (flv_halted) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    end else if (size > 24'd64) begin
      repeat (3) send_byte(8'($urandom));
    end else begin
      for (int unsigned k = 0; k < size + 4; k++) send_byte(k == 0 ? first : 8'($urandom));
    end
  endtask

  task automatic test_file_header();
    int unsigned pick;
    logic [31:0] offs;
    logic [7:0]  hdr [9];
    pick = $urandom_range(9);
    offs = 32'd9 + $urandom_range(8);
    if (pick == 9) offs = $urandom_range(8);
    hdr = '{SIG_F, SIG_L, SIG_V, VERSION_ONE, 8'($urandom) & ~FLAG_RSVD_MASK,
            offs[31:24], offs[23:16], offs[15:8], offs[7:0]};
    case (pick)
      6: hdr[$urandom_range(2)] ^= 8'($urandom_range(1, 255));
      7: hdr[3] = VERSION_ONE ^ 8'($urandom_range(1, 255));
      8: hdr[4] = hdr[4] | (FLAG_RSVD_MASK & (8'($urandom) | 8'h40));
      default: ;
    endcase
    foreach (hdr[k]) send_byte(hdr[k]);
    if (flv_halted) begin
      repeat (3) send_byte(8'($urandom));
      seek_to(48'd13);
    end else begin
      repeat (offs - 32'd9 + 32'd4) send_byte(8'($urandom));
    end
  endtask

  task automatic test_audio_tags();
    send_tag(TAG_AUDIO, 24'd1, 32'hFFFF_FFFF, 24'd0, {AUDIO_FMT_AAC, 4'hF});
    send_tag(TAG_AUDIO, 24'd3, 32'h0000_0000, 24'd0, 8'h2E);
    send_tag(TAG_AUDIO, 24'd0, 32'h8000_0001, 24'd0, 8'hA0);
  endtask

  task automatic test_video_tags();
    send_tag(TAG_VIDEO, 24'd3, 32'h0012_3456, 24'd0, {4'h1, VIDEO_CODEC_AVC});
    send_tag(TAG_VIDEO, 24'd9, 32'hFF00_00FF, 24'd0, {4'h2, VIDEO_CODEC_AVC});
    send_tag(TAG_VIDEO, 24'd2, 32'h0000_0010, 24'd0, {4'h1, VIDEO_CODEC_VP6});
    send_tag(TAG_VIDEO, 24'd6, 32'h0000_0020, 24'd0, {4'h3, VIDEO_CODEC_VP6A});
    send_tag(TAG_VIDEO, 24'd1, 32'h00FF_FFFF, 24'd0, 8'hFF);
    send_tag(TAG_VIDEO, 24'd0, 32'h0000_0000, 24'd0, 8'h00);
  endtask

  task automatic test_script_tags();
    send_tag(TAG_SCRIPT, 24'd5, 32'h0000_0000, 24'd0, 8'h02);
    send_tag(TAG_SCRIPT, 24'd0, 32'hFFFF_FFFF, 24'd0, 8'h02);
  endtask

  task automatic test_stream_errors();
    send_tag(TAG_VIDEO, 24'd4, 32'h0000_0100, 24'h000001, 8'h17);
    send_tag(TAG_AUDIO, 24'd2, 32'h0000_0200, 24'h800000, 8'hAF);
    send_tag(8'hFF, 24'd3, 32'h0000_0300, 24'd0, 8'h00);
    send_tag(8'h00, 24'd3, 32'h0000_0400, 24'd0, 8'h00);
    send_tag(TAG_VIDEO, 24'hFF_FFFF, 32'h0000_0500, 24'd0, 8'h17);
  endtask

  task automatic test_seek_wrap();
    seek_to(48'hFFFF_FFFF_FFF9);
    send_tag(TAG_SCRIPT, 24'd2, 32'h0000_0001, 24'd0, 8'h02);
    repeat (5) send_byte(8'($urandom));
    seek_to(48'h0);
    send_tag(TAG_AUDIO, 24'd4, 32'h0000_0002, 24'd0, 8'h3F);
    seek_to(48'hFFFF_FFFF_FFFF);
    send_tag(TAG_VIDEO, 24'd2, 32'h0000_0003, 24'd0, 8'h12);
  endtask

  task automatic test_random_streams(input int unsigned count, input int unsigned send_pct,
                                     input int unsigned recv_pct);
    int unsigned target;
    int unsigned pick;
    logic [7:0]  kind;
    logic [23:0] size;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    target = parsed_items + count;
    while (parsed_items < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        case ($urandom_range(2))
          0: kind = TAG_AUDIO;
          1: kind = TAG_VIDEO;
          default: kind = TAG_SCRIPT;
        endcase
        size = ($urandom_range(99) < 85) ? 24'($urandom_range(8))
                                         : 24'($urandom_range(9, 48));
        send_tag(kind, size, $urandom, 24'd0, 8'($urandom));
      end else if (pick < 78) begin
        do kind = 8'($urandom);
        while (kind == TAG_AUDIO || kind == TAG_VIDEO || kind == TAG_SCRIPT);
        send_tag(kind, 24'($urandom_range(8)), $urandom, 24'd0, 8'($urandom));
      end else if (pick < 84) begin
        send_tag(TAG_AUDIO, 24'($urandom_range(8)), $urandom,
                 24'($urandom_range(1, 24'hFF_FFFF)), 8'($urandom));
      end else if (pick < 90) begin
        if ($urandom_range(4) == 0) seek_to(48'hFFFF_FFFF_FFFF - 48'($urandom_range(40)));
        else seek_to(rand_pos());
      end else begin
        repeat ($urandom_range(1, 15)) send_byte(8'($urandom));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin : descriptor_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (descriptor_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: descriptor expected none actual kind %0d status %0d position 0x%0h",
                 $time, block_kind_o, status_o, stream_pos_o);
      end else begin
        want = descriptor_q.pop_front();
        descriptors_checked++;
        check_field("status", 48'(want.status), 48'(status_o));
        check_field("block_kind", 48'(want.block_kind), 48'(block_kind_o));
        check_field("tag_code", 48'(want.tag_code), 48'(tag_code_o));
        check_field("body_len", 48'(want.body_len), 48'(body_len_o));
        check_field("timestamp", 48'(want.timestamp), 48'(timestamp_o));
        check_field("format_high", 48'(want.format_high), 48'(format_high_o));
        check_field("format_low", 48'(want.format_low), 48'(format_low_o));
        check_field("has_audio", 48'(want.has_audio), 48'(has_audio_o));
        check_field("has_video", 48'(want.has_video), 48'(has_video_o));
        check_field("packet_offset", 48'(want.packet_offset), 48'(packet_offset_o));
        check_field("packet_size", 48'(want.packet_size), 48'(packet_size_o));
        check_field("stream_pos", want.stream_pos, stream_pos_o);
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct = 21;
    recv_stall_pct = 51;
    test_file_header();
    test_audio_tags();
    test_video_tags();
    test_script_tags();
    test_stream_errors();
    test_seek_wrap();
    test_random_streams(170, 21, 51);
    test_random_streams(170, 51, 21);
    test_random_streams(170, 0, 0);
    in_valid_i <= 1'b0;
    while (descriptor_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("summary: %0d input transfers with %0d seeks, %0d descriptors compared",
             transfers_in, seeks_sent, descriptors_checked);
    $display("summary: %0d field mismatches, %0d descriptors outstanding",
             mismatches, descriptor_q.size());
    if (mismatches == 0 && descriptor_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
hdl/flvp_pkg.sv
hdl/flvp_parser.sv
hdl/flv_tag_stream_parser.sv
bench/flv_tag_stream_parser_tb.sv
